FILE: design/zone_poll_response_checker_assert.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ZONE_POLL_RESPONSE_CHECKER_ASSERT_SVH
`define ZONE_POLL_RESPONSE_CHECKER_ASSERT_SVH

// Same-cycle implication.
`define ZPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ZPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/zpr_pkg.sv
package zpr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SLOT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_POLL_WAIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_ID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_TABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_VALID = 3'd5;

  localparam logic [2:0] EV_POLL     = 3'd0;
  localparam logic [2:0] EV_BYTE     = 3'd1;
  localparam logic [2:0] EV_TIMEOUT  = 3'd2;
  localparam logic [2:0] EV_BADSTART = 3'd3;
  localparam logic [2:0] EV_BADSUM   = 3'd4;
  localparam logic [2:0] EV_MISMATCH = 3'd5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [7:0]  START_BYTE = 8'h10;
  localparam logic [7:0]  CHECK_XOR  = 8'h55;
  localparam logic [15:0] TIMER_MAX  = 16'hffff;

  localparam logic [15:0] REPLY_WAIT_RST = 16'd500;

  typedef struct packed {
    logic [15:0] poll_wait;
    logic [15:0] reply_wait;
    logic [7:0]  request_id;
    logic [3:0]  device_count;
    logic [63:0] zone_table;
    logic [7:0]  zone_valid;
  } zpr_cfg_t;

endpackage

FILE: design/zone_poll_response_checker.sv
// Ticks and bytes: one transaction per cycle while in_stall is low; a poll request or
// status result is in the output register in the cycle after its transaction is taken.
// A byte that closes a good frame enters the EMIT state and streams FRAME_LENGTH frame
// bytes, one per cycle while out_stall is low, through the frame memory's read register
// to the output register; input waits until the last byte is in the output register.
// Synchronous active-low reset: configuration to defaults, slot pointer to 0.
module zone_poll_response_checker import zpr_pkg::*; #(
  parameter int MAX_DEVICES  = 8,
  parameter int FRAME_LENGTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_res,
  output logic [7:0]            out_zone,
  output logic [7:0]            out_req_id_out,
  output logic [7:0]            out_frame_data,
  output logic [3:0]            out_byte_index,
  output logic                  out_last
);

  localparam int IDX_W = $clog2(FRAME_LENGTH);

  zpr_cfg_t cfg_r;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_wait    <= 16'd0;
      cfg_r.reply_wait   <= REPLY_WAIT_RST;
      cfg_r.request_id   <= 8'd0;
      cfg_r.device_count <= 4'd0;
      cfg_r.zone_table   <= 64'd0;
      cfg_r.zone_valid   <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL_WAIT:  cfg_r.poll_wait    <= cfg_data[15:0];
        CFG_REPLY_WAIT: cfg_r.reply_wait   <= cfg_data[15:0];
        CFG_REQUEST_ID: cfg_r.request_id   <= cfg_data[7:0];
        CFG_DEV_COUNT:  cfg_r.device_count <= cfg_data[3:0];
        CFG_ZONE_TABLE: cfg_r.zone_table   <= cfg_data[63:0];
        CFG_ZONE_VALID: cfg_r.zone_valid   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  zpr_ctrl #(
    .MAX_DEVICES  (MAX_DEVICES),
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_zone       (out_zone),
    .out_req_id_out (out_req_id_out),
    .out_frame_data (out_frame_data),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .mem_wr_en      (wr_en),
    .mem_wr_addr    (wr_addr),
    .mem_wr_data    (wr_data),
    .mem_rd_en      (rd_en),
    .mem_rd_addr    (rd_addr),
    .mem_rd_data    (rd_data)
  );

  zpr_frame_mem #(
    .DEPTH (FRAME_LENGTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: design/zpr_frame_mem.sv
module zpr_frame_mem import zpr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/zpr_ctrl.sv
`include "zone_poll_response_checker_assert.svh"

module zpr_ctrl import zpr_pkg::*; #(
  parameter int MAX_DEVICES  = 8,
  parameter int FRAME_LENGTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  zpr_cfg_t                        cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_event_res,
  output logic [7:0]                      out_zone,
  output logic [7:0]                      out_req_id_out,
  output logic [7:0]                      out_frame_data,
  output logic [3:0]                      out_byte_index,
  output logic                            out_last,
  output logic                            mem_wr_en,
  output logic [$clog2(FRAME_LENGTH)-1:0] mem_wr_addr,
  output logic [7:0]                      mem_wr_data,
  output logic                            mem_rd_en,
  output logic [$clog2(FRAME_LENGTH)-1:0] mem_rd_addr,
  input  logic [7:0]                      mem_rd_data
);

  localparam int IDX_W = $clog2(FRAME_LENGTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LENGTH - 1);
  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_LENGTH);
  localparam logic [3:0] DEV_MAX = 4'(MAX_DEVICES);

  typedef enum logic {ST_IDLE, ST_EMIT} ctrl_state_t;
  typedef enum logic [1:0] {MODE_POLL, MODE_START, MODE_BODY} mode_t;

  ctrl_state_t       state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [15:0]       poll_el_r, poll_el_nxt;
  logic [15:0]       reply_el_r, reply_el_nxt;
  logic [7:0]        awaited_r, awaited_nxt;
  logic [IDX_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        id_byte_r, id_byte_nxt;
  logic [7:0]        zone_byte_r, zone_byte_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        ev_r, ev_nxt;
  logic [7:0]        zone_r, zone_nxt;
  logic [7:0]        rid_r, rid_nxt;
  logic [7:0]        data_r, data_nxt;
  logic [3:0]        bidx_r, bidx_nxt;
  logic              last_r, last_nxt;

  logic              accept, out_free, fire, issue, emit_last, load, id_ok;
  logic [3:0]        count, slot_inc;
  logic [SLOT_W-1:0] slot_adv;
  logic [15:0]       poll_inc, reply_inc;
  logic [IDX_W+3:0]  idx_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  assign count     = (cfg.device_count > DEV_MAX) ? DEV_MAX : cfg.device_count;
  assign slot_inc  = {1'b0, slot_r} + 4'd1;
  assign slot_adv  = (slot_inc > count - 4'd1) ? '0 : slot_inc[SLOT_W-1:0];
  assign poll_inc  = (poll_el_r == TIMER_MAX) ? poll_el_r : poll_el_r + 16'd1;
  assign reply_inc = (reply_el_r == TIMER_MAX) ? reply_el_r : reply_el_r + 16'd1;
  assign id_ok     = (id_byte_r == cfg.request_id) ||
                     ((cfg.request_id != 8'd0) && (id_byte_r == cfg.request_id - 8'd1));

  assign fire      = (state_r == ST_EMIT) && pend_r && out_free;
  assign issue     = (state_r == ST_EMIT) && (rd_idx_r != FRAME_CNT) && (!pend_r || fire);
  assign emit_last = (emit_idx_r == LAST_IDX);
  assign idx_ext   = {4'b0000, emit_idx_r};

  assign mem_rd_en   = issue;
  assign mem_rd_addr = rd_idx_r[IDX_W-1:0];
  assign mem_wr_data = in_rx_byte;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    slot_nxt      = slot_r;
    poll_el_nxt   = poll_el_r;
    reply_el_nxt  = reply_el_r;
    awaited_nxt   = awaited_r;
    byte_cnt_nxt  = byte_cnt_r;
    sum_nxt       = sum_r;
    id_byte_nxt   = id_byte_r;
    zone_byte_nxt = zone_byte_r;
    rd_idx_nxt    = rd_idx_r;
    emit_idx_nxt  = emit_idx_r;
    pend_nxt      = pend_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = byte_cnt_r;
    load          = 1'b0;
    ev_nxt        = EV_POLL;
    zone_nxt      = awaited_r;
    rid_nxt       = 8'd0;
    data_nxt      = 8'd0;
    bidx_nxt      = 4'd0;
    last_nxt      = 1'b1;

    if (accept) begin
      if (in_operation == OP_TICK) begin
        poll_el_nxt  = poll_inc;
        reply_el_nxt = reply_inc;
        if (count != 4'd0) begin
          if (mode_r != MODE_POLL) begin
            if (reply_inc > cfg.reply_wait) begin
              load         = 1'b1;
              ev_nxt       = EV_TIMEOUT;
              mode_nxt     = MODE_POLL;
              byte_cnt_nxt = '0;
              sum_nxt      = 8'd0;
            end
          end else if (poll_inc >= cfg.poll_wait) begin
            poll_el_nxt = 16'd0;
            slot_nxt    = slot_adv;
            if (cfg.zone_valid[slot_adv]) begin
              awaited_nxt  = cfg.zone_table[{slot_adv, 3'b000} +: 8];
              load         = 1'b1;
              ev_nxt       = EV_POLL;
              zone_nxt     = cfg.zone_table[{slot_adv, 3'b000} +: 8];
              rid_nxt      = cfg.request_id;
              mode_nxt     = MODE_START;
              reply_el_nxt = 16'd0;
              byte_cnt_nxt = '0;
              sum_nxt      = 8'd0;
            end
          end
        end
      end else if (count != 4'd0) begin
        case (mode_r)
          MODE_START: begin
            if (in_rx_byte != START_BYTE) begin
              load         = 1'b1;
              ev_nxt       = EV_BADSTART;
              mode_nxt     = MODE_POLL;
              byte_cnt_nxt = '0;
              sum_nxt      = 8'd0;
            end else begin
              mem_wr_en    = 1'b1;
              mem_wr_addr  = '0;
              byte_cnt_nxt = IDX_W'(1);
              sum_nxt      = in_rx_byte;
              mode_nxt     = MODE_BODY;
            end
          end
          MODE_BODY: begin
            mem_wr_en = 1'b1;
            if (byte_cnt_r == IDX_W'(2)) begin
              id_byte_nxt = in_rx_byte;
            end
            if (byte_cnt_r == IDX_W'(4)) begin
              zone_byte_nxt = in_rx_byte;
            end
            if (byte_cnt_r != LAST_IDX) begin
              sum_nxt      = sum_r + in_rx_byte;
              byte_cnt_nxt = byte_cnt_r + IDX_W'(1);
            end else begin
              mode_nxt     = MODE_POLL;
              byte_cnt_nxt = '0;
              sum_nxt      = 8'd0;
              if (in_rx_byte != (sum_r ^ CHECK_XOR)) begin
                load   = 1'b1;
                ev_nxt = EV_BADSUM;
              end else if ((zone_byte_r != awaited_r) || !id_ok) begin
                load   = 1'b1;
                ev_nxt = EV_MISMATCH;
              end else begin
                state_nxt    = ST_EMIT;
                rd_idx_nxt   = '0;
                emit_idx_nxt = '0;
                pend_nxt     = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (issue) begin
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
      pend_nxt   = 1'b1;
    end else if (fire) begin
      pend_nxt = 1'b0;
    end

    if (fire) begin
      load         = 1'b1;
      ev_nxt       = EV_BYTE;
      data_nxt     = mem_rd_data;
      bidx_nxt     = idx_ext[3:0];
      last_nxt     = emit_last;
      emit_idx_nxt = emit_idx_r + IDX_W'(1);
      if (emit_last) begin
        state_nxt = ST_IDLE;
      end
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r   <= ev_nxt;
      zone_r <= zone_nxt;
      rid_r  <= rid_nxt;
      data_r <= data_nxt;
      bidx_r <= bidx_nxt;
      last_r <= last_nxt;
    end
    id_byte_r   <= id_byte_nxt;
    zone_byte_r <= zone_byte_nxt;
    emit_idx_r  <= emit_idx_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_POLL;
      slot_r      <= '0;
      poll_el_r   <= 16'd0;
      reply_el_r  <= 16'd0;
      awaited_r   <= 8'd0;
      byte_cnt_r  <= '0;
      sum_r       <= 8'd0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      slot_r      <= slot_nxt;
      poll_el_r   <= poll_el_nxt;
      reply_el_r  <= reply_el_nxt;
      awaited_r   <= awaited_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      sum_r       <= sum_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = ev_r;
  assign out_zone       = zone_r;
  assign out_req_id_out = rid_r;
  assign out_frame_data = data_r;
  assign out_byte_index = bidx_r;
  assign out_last       = last_r;

  `ZPR_ASSERT_IMP(a_no_wr_in_emit, mem_wr_en, state_r == ST_IDLE, "frame write during emit")
  `ZPR_ASSERT_IMP(a_status_last, out_valid_r && (ev_r != EV_BYTE), last_r, "status not last")
  `ZPR_ASSERT_IMP(a_last_idx, out_valid_r && (ev_r == EV_BYTE) && last_r,
                  bidx_r == idx_ext[3:0] - 4'd1, "last byte index off")
  `ZPR_ASSERT_IMP(a_rd_bound, state_r == ST_EMIT, rd_idx_r <= FRAME_CNT, "read past frame")
  `ZPR_ASSERT_NXT(a_emit_done, fire && emit_last, state_r == ST_IDLE, "emit did not finish")

endmodule

FILE: tb/sv/zone_poll_response_checker_tb.sv
`timescale 1ns / 1ps

module zone_poll_response_checker_tb;
  import zpr_pkg::*;

  localparam int FRAME_LEN = 16;
  localparam int MAX_DEV = 8;
  localparam int DRAIN_CYCLES = FRAME_LEN + 4;
  localparam int LONG_HOLD = 300;
  localparam int POLL_TRIES = 200;

  typedef enum logic [1:0] {ST_POLL, ST_START, ST_BODY} link_state_t;

  typedef enum int {
    RK_GOOD, RK_PREV_ID, RK_BAD_SUM, RK_BAD_ZONE, RK_BAD_ID, RK_BAD_START, RK_SHORT
  } reply_kind_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] zone;
    logic [7:0] req_id;
    logic [7:0] data;
    logic [3:0] idx;
    logic       fin;
  } bus_result_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } bus_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = OP_TICK;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_event_res;
  logic [7:0]            out_zone;
  logic [7:0]            out_req_id_out;
  logic [7:0]            out_frame_data;
  logic [3:0]            out_byte_index;
  logic                  out_last;

  zone_poll_response_checker #(
    .MAX_DEVICES (MAX_DEV),
    .FRAME_LENGTH(FRAME_LEN)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_zone      (out_zone),
    .out_req_id_out(out_req_id_out),
    .out_frame_data(out_frame_data),
    .out_byte_index(out_byte_index),
    .out_last      (out_last)
  );

  // Shadow registers, reset values.
  logic [15:0] poll_wait_lim = 16'd0;
  logic [15:0] reply_wait_lim = REPLY_WAIT_RST;
  logic [7:0]  poll_id = 8'd0;
  logic [3:0]  dev_count = 4'd0;
  logic [63:0] zone_map = 64'd0;
  logic [7:0]  zone_ok = 8'd0;

  // Shadow link state.
  link_state_t link_state = ST_POLL;
  logic [2:0]  slot_index = 3'd0;
  logic [15:0] poll_elapsed = 16'd0;
  logic [15:0] reply_elapsed = 16'd0;
  logic [7:0]  awaited_zone = 8'd0;
  logic [4:0]  byte_count = 5'd0;
  logic [7:0]  running_sum = 8'd0;
  logic [7:0]  frame_buf [FRAME_LEN];

  bus_item_t   pend_q[$];
  bus_result_t expected_q[$];
  int          n_pushed = 0;
  int          n_accepted = 0;
  int          n_fail = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  bit          long_hold_asked = 1'b0;
  bit          no_idle = 1'b0;
  int          seq_no = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void push_result(logic [2:0] ev, logic [7:0] zn, logic [7:0] id,
                                      logic [7:0] data, logic [3:0] idx, logic fin);
    bus_result_t r;
    r = '{ev, zn, id, data, idx, fin};
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void close_reply(logic [2:0] ev);
    push_result(ev, awaited_zone, 8'h00, 8'h00, 4'h0, 1'b1);
    link_state = ST_POLL;
    byte_count = 5'd0;
    running_sum = 8'd0;
  endfunction

  function automatic void model_item(logic op, logic [7:0] b);
    int   n_dev;
    int   k;
    logic id_ok;
    n_dev = (dev_count > MAX_DEV) ? MAX_DEV : int'(dev_count);
    if (op == OP_TICK) begin
      if (poll_elapsed != TIMER_MAX) poll_elapsed++;
      if (reply_elapsed != TIMER_MAX) reply_elapsed++;
      if (n_dev == 0) return;
      if (link_state != ST_POLL) begin
        if (reply_elapsed > reply_wait_lim) close_reply(EV_TIMEOUT);
        return;
      end
      if (poll_elapsed < poll_wait_lim) return;
      poll_elapsed = 16'd0;
      slot_index = (int'(slot_index) + 1 > n_dev - 1) ? 3'd0 : slot_index + 3'd1;
      if (!zone_ok[slot_index]) return;
      awaited_zone = zone_map[8*slot_index +: 8];
      push_result(EV_POLL, awaited_zone, poll_id, 8'h00, 4'h0, 1'b1);
      link_state = ST_START;
      reply_elapsed = 16'd0;
      byte_count = 5'd0;
      running_sum = 8'd0;
      return;
    end
    if (n_dev == 0) return;
    if (link_state == ST_START) begin
      if (b != START_BYTE) begin
        close_reply(EV_BADSTART);
        return;
      end
      frame_buf[0] = b;
      byte_count = 5'd1;
      running_sum = b;
      link_state = ST_BODY;
      return;
    end
    if (link_state != ST_BODY) return;
    if (byte_count >= FRAME_LEN) byte_count = 5'(FRAME_LEN - 1);
    frame_buf[byte_count[3:0]] = b;
    if (byte_count < FRAME_LEN - 1) running_sum = running_sum + b;
    byte_count++;
    if (byte_count < FRAME_LEN) return;
    if (frame_buf[FRAME_LEN-1] != (running_sum ^ CHECK_XOR)) begin
      close_reply(EV_BADSUM);
      return;
    end
    id_ok = (frame_buf[2] == poll_id) || (poll_id != 8'd0 && frame_buf[2] == poll_id - 8'd1);
    if (frame_buf[4] != awaited_zone || !id_ok) begin
      close_reply(EV_MISMATCH);
      return;
    end
    for (k = 0; k < FRAME_LEN; k++)
      push_result(EV_BYTE, awaited_zone, 8'h00, frame_buf[k], k[3:0], k == FRAME_LEN - 1);
    link_state = ST_POLL;
    byte_count = 5'd0;
    running_sum = 8'd0;
  endfunction

  always @(posedge clk) begin : drive
    bus_item_t nxt;
    if (in_valid && !in_stall) begin
      model_item(in_operation, in_rx_byte);
      n_accepted++;
    end
    if (!(in_valid && in_stall)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt = pend_q.pop_front();
        in_valid <= 1'b1;
        in_operation <= nxt.op;
        in_rx_byte <= nxt.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    bus_result_t got;
    bus_result_t want;
    if (out_valid && !out_stall) begin
      got = '{out_event_res, out_zone, out_req_id_out, out_frame_data, out_byte_index,
              out_last};
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result: ev=%0d zone=%h id=%h data=%h idx=%0d last=%b",
                   got.ev, got.zone, got.req_id, got.data, got.idx, got.fin);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("mismatch: exp ev=%0d zone=%h id=%h data=%h idx=%0d last=%b",
                     want.ev, want.zone, want.req_id, want.data, want.idx, want.fin);
            $display("          got ev=%0d zone=%h id=%h data=%h idx=%0d last=%b",
                     got.ev, got.zone, got.req_id, got.data, got.idx, got.fin);
          end
        end
      end
    end
    if (long_hold_asked && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void send_raw(logic op, logic [7:0] b);
    bus_item_t it;
    it = '{op, b};
    pend_q.insert(pend_q.size(), it);
    n_pushed++;
  endfunction

  function automatic void send_tick();
    send_raw(OP_TICK, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void send_reply(reply_kind_t kind, logic [7:0] zn, logic [7:0] id);
    logic [7:0] fr [FRAME_LEN];
    logic [7:0] chk;
    int         n_send;
    int         k;
    for (k = 0; k < FRAME_LEN; k++) fr[k] = 8'($urandom_range(0, 255));
    fr[0] = START_BYTE;
    fr[4] = zn;
    case (kind)
      RK_PREV_ID: fr[2] = id - 8'd1;
      RK_BAD_ID:  fr[2] = id + 8'd1 + 8'($urandom_range(0, 253));
      default:    fr[2] = id;
    endcase
    if (kind == RK_BAD_ZONE) fr[4] = zn ^ 8'($urandom_range(1, 255));
    if (kind == RK_BAD_START) fr[0] = START_BYTE ^ 8'($urandom_range(1, 255));
    chk = 8'h00;
    for (k = 0; k < FRAME_LEN - 1; k++) chk = chk + fr[k];
    fr[FRAME_LEN-1] = chk ^ CHECK_XOR;
    if (kind == RK_BAD_SUM) fr[FRAME_LEN-1] ^= 8'($urandom_range(1, 255));
    n_send = (kind == RK_SHORT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
    for (k = 0; k < n_send; k++) begin
      if ($urandom_range(0, 9) == 0) send_tick();
      send_raw(OP_BYTE, fr[k]);
    end
  endfunction

  task automatic wait_accepted();
    while (n_accepted != n_pushed) @(posedge clk);
  endtask

  task automatic drain();
    wait_accepted();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_POLL_WAIT:  poll_wait_lim = val[15:0];
      CFG_REPLY_WAIT: reply_wait_lim = val[15:0];
      CFG_REQUEST_ID: poll_id = val[7:0];
      CFG_DEV_COUNT:  dev_count = val[3:0];
      CFG_ZONE_TABLE: zone_map = val;
      CFG_ZONE_VALID: zone_ok = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] pw, logic [15:0] rw, logic [7:0] id,
                            logic [3:0] dc, logic [63:0] zt, logic [7:0] zm);
    cfg_write(CFG_POLL_WAIT, 64'(pw));
    cfg_write(CFG_REPLY_WAIT, 64'(rw));
    cfg_write(CFG_REQUEST_ID, 64'(id));
    cfg_write(CFG_DEV_COUNT, 64'(dc));
    cfg_write(CFG_ZONE_TABLE, zt);
    cfg_write(CFG_ZONE_VALID, 64'(zm));
  endtask

  // Poll until a reply is awaited, then answer it; every other reply is RK_GOOD.
  task automatic run_polls(int n_items);
    int          start;
    int          tries;
    int          k;
    reply_kind_t kind;
    start = n_pushed;
    while (n_pushed - start < n_items) begin
      wait_accepted();
      if ($urandom_range(0, 3) == 0)
        for (k = $urandom_range(1, 3); k > 0; k--)
          send_raw(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      tries = 0;
      do begin
        if (link_state == ST_BODY) send_raw(OP_BYTE, 8'($urandom_range(0, 255)));
        else send_tick();
        wait_accepted();
        tries++;
      end while (link_state != ST_START && tries < POLL_TRIES);
      if (link_state == ST_START) begin
        kind = (seq_no % 2 == 0) ? RK_GOOD : reply_kind_t'((seq_no / 2) % 6 + 1);
        seq_no++;
        send_reply(kind, awaited_zone, poll_id);
      end
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No devices: nothing comes out.
    send_tick();
    send_raw(OP_BYTE, START_BYTE);
    drain();

    set_config(16'd0, REPLY_WAIT_RST, 8'd0, 4'd1, {$urandom, $urandom}, 8'h01);
    send_tick();
    send_reply(RK_GOOD, zone_map[7:0], 8'd0);
    send_tick();
    send_raw(OP_BYTE, 8'hff);
    send_tick();
    send_raw(OP_BYTE, 8'h00);
    send_raw(OP_BYTE, START_BYTE);
    drain();

    // Zero reply wait times out on the next tick.
    set_config(16'd0, 16'd0, 8'h5a, 4'd1, {$urandom, $urandom}, 8'h01);
    send_tick();
    send_tick();
    drain();

    set_config(16'd0, 16'hffff, 8'hff, 4'd8, {$urandom, $urandom}, 8'hff);
    long_hold_asked = 1'b1;
    run_polls(40);

    set_config(16'd3, 16'd25, 8'($urandom_range(1, 254)), 4'd3, {$urandom, $urandom},
               8'($urandom_range(0, 255)) | 8'h01);
    run_polls(40);

    set_config(16'd1, 16'd0, 8'd0, 4'd15, 64'hffff_ffff_ffff_ffff, 8'ha5);
    run_polls(35);

    no_idle = 1'b1;
    set_config(16'd0, 16'd60, 8'($urandom_range(0, 255)), 4'd5, {$urandom, $urandom},
               8'($urandom_range(0, 255)) | 8'h01);
    run_polls(35);

    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
